// ----- design/cpt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Clarke/Park frame transform.
// No dependencies.
package cpt_pkg;

    localparam int CPT_DATA_WIDTH = 16;

    // Q30 coefficients and their shift
    localparam int CPT_K_SHIFT = 30;
    localparam logic [CPT_K_SHIFT-1:0] CPT_K_INV_SQRT3  = 30'd619925131;
    localparam logic [CPT_K_SHIFT-1:0] CPT_K_SQRT3_HALF = 30'd929887697;

    localparam logic CPT_MODE_FWD = 1'b0;
    localparam logic CPT_MODE_INV = 1'b1;

    typedef struct packed {
        logic valid;
        logic mode;
    } cpt_tag_t;

    // One radix-16 step of a divide by three: v = {remainder, digit}.
    // Returns {quotient digit, new remainder}. 43/128 is close enough to 1/3
    // for v below 48.
    function automatic logic [5:0] cpt_div3_digit(input logic [5:0] v);
        logic [11:0] p;
        logic [3:0]  q;
        logic [5:0]  r;
        p = 12'(v) * 12'd43;
        q = p[10:7];
        r = v - 6'(q) * 6'd3;
        return {q, r[1:0]};
    endfunction

endpackage

// ----- design/cpt_clarke_fwd.sv -----
`timescale 1ns / 1ps
// Forward Clarke transform, four register stages, sign-magnitude results.
// Depends on cpt_pkg.
module cpt_clarke_fwd #(
    parameter int DATA_WIDTH = cpt_pkg::CPT_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpt_pkg::cpt_tag_t            tag_in,
    input  logic signed [DATA_WIDTH-1:0] phase_a,
    input  logic signed [DATA_WIDTH-1:0] phase_b,
    input  logic signed [DATA_WIDTH-1:0] phase_c,
    output cpt_pkg::cpt_tag_t            tag_out,
    output logic        [DATA_WIDTH-1:0] alpha_mag,
    output logic                         alpha_neg,
    output logic        [DATA_WIDTH-1:0] beta_mag,
    output logic                         beta_neg
);
    import cpt_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int TW = W + 3;                  // 2a - b - c
    localparam int NW = W + 2;                  // |t| + 1
    localparam int ND = (NW + 3) / 4;           // radix-16 digits
    localparam int NL = ND / 2;                 // digits done in stage 4
    localparam int NH = ND - NL;                // digits done in stage 3
    localparam int PW = W + 1 + CPT_K_SHIFT;    // |b - c| * K

    cpt_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    // stage 1
    logic signed [TW-1:0] t_reg, t_next;
    logic signed [W:0]    diff_reg, diff_next;
    // stage 2
    logic [NW-1:0]        tmag_reg, tmag_next;
    logic [W:0]           dmag_reg, dmag_next;
    logic                 tneg2_reg, dneg2_reg;
    // stage 3
    logic [NH*4-1:0]      qhi_reg, qhi_next;
    logic [1:0]           rem_reg, rem_next;
    logic [NL*4-1:0]      tlo_reg;
    logic [PW-1:0]        bprod_reg, bprod_next;
    logic                 tneg3_reg, dneg3_reg;
    // stage 4
    logic [W-1:0]         alpha_mag_reg, alpha_mag_next;
    logic [W-1:0]         beta_mag_reg, beta_mag_next;
    logic                 alpha_neg_reg, beta_neg_reg;

    logic [ND*4-1:0]      tpad;
    logic [NL*4-1:0]      qlo;
    logic [ND*4-1:0]      quot;
    logic [PW-1:0]        bsum;

    assign t_next    = (TW'(phase_a) <<< 1) - TW'(phase_b) - TW'(phase_c);
    assign diff_next = (W+1)'(phase_b) - (W+1)'(phase_c);

    // |t| + 1, the +1 rounds the divide by three to nearest
    assign tmag_next = t_reg[TW-1] ? NW'(~t_reg + TW'(2)) : NW'(t_reg + TW'(1));
    assign dmag_next = diff_reg[W] ? (W+1)'(-diff_reg) : (W+1)'(diff_reg);

    assign tpad       = (ND*4)'(tmag_reg);
    assign bprod_next = PW'(dmag_reg) * PW'(CPT_K_INV_SQRT3);

    always_comb
    begin : div_hi
        logic [1:0] r;
        logic [5:0] st;
        r        = 2'd0;
        qhi_next = '0;
        for (int k = 0; k < NH; k++)
        begin
            st = cpt_div3_digit({r, tpad[(ND-1-k)*4 +: 4]});
            qhi_next[(NH-1-k)*4 +: 4] = st[5:2];
            r = st[1:0];
        end
        rem_next = r;
    end

    always_comb
    begin : div_lo
        logic [1:0] r;
        logic [5:0] st;
        r   = rem_reg;
        qlo = '0;
        for (int k = 0; k < NL; k++)
        begin
            st = cpt_div3_digit({r, tlo_reg[(NL-1-k)*4 +: 4]});
            qlo[(NL-1-k)*4 +: 4] = st[5:2];
            r = st[1:0];
        end
    end

    assign quot           = {qhi_reg, qlo};
    assign alpha_mag_next = quot[W-1:0];
    assign bsum           = bprod_reg + (PW'(1) << (CPT_K_SHIFT - 1));
    assign beta_mag_next  = bsum[W+CPT_K_SHIFT-1:CPT_K_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        diff_reg      <= diff_next;
        tmag_reg      <= tmag_next;
        dmag_reg      <= dmag_next;
        tneg2_reg     <= t_reg[TW-1];
        dneg2_reg     <= diff_reg[W];
        qhi_reg       <= qhi_next;
        rem_reg       <= rem_next;
        tlo_reg       <= tpad[NL*4-1:0];
        bprod_reg     <= bprod_next;
        tneg3_reg     <= tneg2_reg;
        dneg3_reg     <= dneg2_reg;
        alpha_mag_reg <= alpha_mag_next;
        beta_mag_reg  <= beta_mag_next;
        alpha_neg_reg <= tneg3_reg;
        beta_neg_reg  <= dneg3_reg;
    end

    assign tag_out   = tag4_reg;
    assign alpha_mag = alpha_mag_reg;
    assign alpha_neg = alpha_neg_reg;
    assign beta_mag  = beta_mag_reg;
    assign beta_neg  = beta_neg_reg;

endmodule

// ----- design/cpt_park.sv -----
`timescale 1ns / 1ps
// Shared rotation unit: four rounded products and two sums, three stages.
// Serves the Park rotation (forward) and its inverse. Depends on cpt_pkg.
module cpt_park #(
    parameter int DATA_WIDTH = cpt_pkg::CPT_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpt_pkg::cpt_tag_t            tag_in,
    input  logic        [DATA_WIDTH-1:0] x_mag,
    input  logic                         x_neg,
    input  logic        [DATA_WIDTH-1:0] y_mag,
    input  logic                         y_neg,
    input  logic        [DATA_WIDTH-1:0] c_mag,
    input  logic                         c_neg,
    input  logic        [DATA_WIDTH-1:0] s_mag,
    input  logic                         s_neg,
    output cpt_pkg::cpt_tag_t            tag_out,
    output logic signed [DATA_WIDTH+2:0] u,
    output logic signed [DATA_WIDTH+2:0] v
);
    import cpt_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int MW = W + 1;
    localparam int SW = W + 3;

    // forward: u = xc + ys, v = yc - xs; inverse: u = xc - ys, v = yc + xs
    logic flip;

    cpt_tag_t tag_a_reg, tag_b_reg, tag_c_reg;

    logic [PW-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic          sxc_a_reg, sys_a_reg, syc_a_reg, sxs_a_reg;
    logic [MW-1:0] mxc_reg, mys_reg, myc_reg, mxs_reg;
    logic          sxc_b_reg, sys_b_reg, syc_b_reg, sxs_b_reg;
    logic signed [SW-1:0] u_reg, u_next, v_reg, v_next;

    function automatic logic [MW-1:0] round_mag(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = p + (PW'(1) << (W - 2));
        return s[PW-1:W-1];
    endfunction

    function automatic logic [SW-1:0] term(input logic [MW-1:0] m, input logic neg);
        return SW'(m) ^ {SW{neg}};
    endfunction

    assign flip = (tag_in.mode == CPT_MODE_INV);

    // two's complement negation folded into the carry-in of one add
    assign u_next = term(mxc_reg, sxc_b_reg) + term(mys_reg, sys_b_reg)
                  + SW'(sxc_b_reg) + SW'(sys_b_reg);
    assign v_next = term(myc_reg, syc_b_reg) + term(mxs_reg, sxs_b_reg)
                  + SW'(syc_b_reg) + SW'(sxs_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pxc_reg   <= PW'(x_mag) * PW'(c_mag);
        pys_reg   <= PW'(y_mag) * PW'(s_mag);
        pyc_reg   <= PW'(y_mag) * PW'(c_mag);
        pxs_reg   <= PW'(x_mag) * PW'(s_mag);
        sxc_a_reg <= x_neg ^ c_neg;
        sys_a_reg <= y_neg ^ s_neg ^ flip;
        syc_a_reg <= y_neg ^ c_neg;
        sxs_a_reg <= x_neg ^ s_neg ^ ~flip;

        mxc_reg   <= round_mag(pxc_reg);
        mys_reg   <= round_mag(pys_reg);
        myc_reg   <= round_mag(pyc_reg);
        mxs_reg   <= round_mag(pxs_reg);
        sxc_b_reg <= sxc_a_reg;
        sys_b_reg <= sys_a_reg;
        syc_b_reg <= syc_a_reg;
        sxs_b_reg <= sxs_a_reg;

        u_reg     <= u_next;
        v_reg     <= v_next;
    end

    assign tag_out = tag_c_reg;
    assign u       = u_reg;
    assign v       = v_reg;

endmodule

// ----- design/cpt_clarke_inv.sv -----
`timescale 1ns / 1ps
// Inverse Clarke transform, saturation and result registers, three stages.
// Forward items pass through saturation only. Depends on cpt_pkg.
module cpt_clarke_inv #(
    parameter int DATA_WIDTH = cpt_pkg::CPT_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cpt_pkg::cpt_tag_t            tag_in,
    input  logic signed [DATA_WIDTH+2:0] u,
    input  logic signed [DATA_WIDTH+2:0] v,
    output logic                         done,
    output logic                         mode_out,
    output logic signed [DATA_WIDTH-1:0] direct_out,
    output logic signed [DATA_WIDTH-1:0] quadrature_out,
    output logic signed [DATA_WIDTH-1:0] phase_a_out,
    output logic signed [DATA_WIDTH-1:0] phase_b_out,
    output logic signed [DATA_WIDTH-1:0] phase_c_out
);
    import cpt_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int KW = CPT_K_SHIFT + 1;
    localparam int SW = W + 2 + KW;
    localparam logic signed [KW-1:0] K2 = {1'b0, CPT_K_SQRT3_HALF};
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (CPT_K_SHIFT - 1);

    cpt_tag_t tag1_reg, tag2_reg;

    logic signed [SW-1:0] bk_reg, bk_next;
    logic signed [SW-1:0] nhalf_reg, nhalf_next;
    logic signed [SW-1:0] sb_reg, sc_reg;
    logic signed [W-1:0]  usat1_reg, vsat1_reg, usat2_reg, vsat2_reg;

    logic                 done_reg, mode_out_reg;
    logic signed [W-1:0]  direct_out_reg, quadrature_out_reg;
    logic signed [W-1:0]  phase_a_out_reg, phase_b_out_reg, phase_c_out_reg;
    logic signed [W-1:0]  b_sat, c_sat;
    logic                 fwd3;

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] x);
        if (x > SAT_MAX)
            return SAT_MAX[W-1:0];
        else if (x < SAT_MIN)
            return SAT_MIN[W-1:0];
        else
            return x[W-1:0];
    endfunction

    // round to nearest, ties away from zero, by the Q30 shift
    function automatic logic signed [SW-1:0] round_q30(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] bias;
        bias = x[SW-1] ? (HALF - SW'(1)) : HALF;
        return (x + bias) >>> CPT_K_SHIFT;
    endfunction

    // inverse-mode beta stays within +-2^W, so W+2 bits carry it
    assign bk_next    = SW'($signed(v[W+1:0])) * SW'(K2);
    assign nhalf_next = -(SW'(u) <<< (CPT_K_SHIFT - 1));

    assign b_sat = sat(round_q30(sb_reg));
    assign c_sat = sat(round_q30(sc_reg));
    assign fwd3  = (tag2_reg.mode == CPT_MODE_FWD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            done_reg     <= 1'b0;
            mode_out_reg <= 1'b0;
        end
        else
        begin
            tag1_reg     <= tag_in;
            tag2_reg     <= tag1_reg;
            done_reg     <= tag2_reg.valid;
            mode_out_reg <= tag2_reg.mode;
        end
    end

    always_ff @(posedge clk)
    begin
        bk_reg    <= bk_next;
        nhalf_reg <= nhalf_next;
        usat1_reg <= sat(SW'(u));
        vsat1_reg <= sat(SW'(v));

        sb_reg    <= bk_reg + nhalf_reg;
        sc_reg    <= nhalf_reg - bk_reg;
        usat2_reg <= usat1_reg;
        vsat2_reg <= vsat1_reg;

        direct_out_reg     <= fwd3 ? usat2_reg : '0;
        quadrature_out_reg <= fwd3 ? vsat2_reg : '0;
        phase_a_out_reg    <= fwd3 ? '0 : usat2_reg;
        phase_b_out_reg    <= fwd3 ? '0 : b_sat;
        phase_c_out_reg    <= fwd3 ? '0 : c_sat;
    end

    assign done           = done_reg;
    assign mode_out       = mode_out_reg;
    assign direct_out     = direct_out_reg;
    assign quadrature_out = quadrature_out_reg;
    assign phase_a_out    = phase_a_out_reg;
    assign phase_b_out    = phase_b_out_reg;
    assign phase_c_out    = phase_c_out_reg;

endmodule

// ----- design/clarke_park_transform.sv -----
`timescale 1ns / 1ps
// Clarke/Park frame transform, forward and inverse, fully pipelined.
// Depends on cpt_pkg, cpt_clarke_fwd, cpt_park, cpt_clarke_inv.
//
// One request per clock: a request is taken on any edge with start high
// (busy is held low), and its result appears on the result ports for one
// cycle, marked by done. The receiver cannot stall. A request passes
// through 4 stages of forward Clarke (sums, magnitudes, divide by three
// and 1/sqrt3 product), 3 stages of the shared rotation unit (products,
// rounding, sums) and 3 stages of inverse Clarke and saturation; inverse
// requests wait in a 4-stage delay line so that both modes use the same
// rotation multipliers in the same slot. mode_out tells which outputs carry
// the result; the others read zero.
module clarke_park_transform #(
    parameter int DATA_WIDTH = cpt_pkg::CPT_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic signed [DATA_WIDTH-1:0] phase_a,
    input  logic signed [DATA_WIDTH-1:0] phase_b,
    input  logic signed [DATA_WIDTH-1:0] phase_c,
    input  logic signed [DATA_WIDTH-1:0] direct_in,
    input  logic signed [DATA_WIDTH-1:0] quadrature_in,
    input  logic signed [DATA_WIDTH-1:0] cos_angle,
    input  logic signed [DATA_WIDTH-1:0] sin_angle,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] direct_out,
    output logic signed [DATA_WIDTH-1:0] quadrature_out,
    output logic signed [DATA_WIDTH-1:0] phase_a_out,
    output logic signed [DATA_WIDTH-1:0] phase_b_out,
    output logic signed [DATA_WIDTH-1:0] phase_c_out,
    output logic                         mode_out
);
    import cpt_pkg::*;

    localparam int W       = DATA_WIDTH;
    localparam int DLY     = 4;     // matches cpt_clarke_fwd
    localparam int LATENCY = 10;

    cpt_tag_t tag_in, fwd_tag, park_tag;

    logic [W-1:0] alpha_mag, beta_mag;
    logic         alpha_neg, beta_neg;

    logic [W-1:0] d_mag_reg [DLY];
    logic [W-1:0] q_mag_reg [DLY];
    logic [W-1:0] c_mag_reg [DLY];
    logic [W-1:0] s_mag_reg [DLY];
    logic [DLY-1:0] d_neg_reg, q_neg_reg, c_neg_reg, s_neg_reg;

    logic [W-1:0] x_mag, y_mag;
    logic         x_neg, y_neg, park_inv;

    logic signed [W+2:0] u, v;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? W'(~x + W'(1)) : W'(x);
    endfunction

    // the pipeline never pushes back
    assign busy   = 1'b0;
    assign tag_in = '{valid: start & ~busy, mode: mode};

    always_ff @(posedge clk)
    begin
        d_mag_reg[0] <= mag(direct_in);
        q_mag_reg[0] <= mag(quadrature_in);
        c_mag_reg[0] <= mag(cos_angle);
        s_mag_reg[0] <= mag(sin_angle);
        d_neg_reg    <= {d_neg_reg[DLY-2:0], direct_in[W-1]};
        q_neg_reg    <= {q_neg_reg[DLY-2:0], quadrature_in[W-1]};
        c_neg_reg    <= {c_neg_reg[DLY-2:0], cos_angle[W-1]};
        s_neg_reg    <= {s_neg_reg[DLY-2:0], sin_angle[W-1]};
        for (int i = 1; i < DLY; i++)
        begin
            d_mag_reg[i] <= d_mag_reg[i-1];
            q_mag_reg[i] <= q_mag_reg[i-1];
            c_mag_reg[i] <= c_mag_reg[i-1];
            s_mag_reg[i] <= s_mag_reg[i-1];
        end
    end

    cpt_clarke_fwd #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_clarke_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (tag_in),
        .phase_a   (phase_a),
        .phase_b   (phase_b),
        .phase_c   (phase_c),
        .tag_out   (fwd_tag),
        .alpha_mag (alpha_mag),
        .alpha_neg (alpha_neg),
        .beta_mag  (beta_mag),
        .beta_neg  (beta_neg)
    );

    assign park_inv = (fwd_tag.mode == CPT_MODE_INV);
    assign x_mag    = park_inv ? d_mag_reg[DLY-1] : alpha_mag;
    assign x_neg    = park_inv ? d_neg_reg[DLY-1] : alpha_neg;
    assign y_mag    = park_inv ? q_mag_reg[DLY-1] : beta_mag;
    assign y_neg    = park_inv ? q_neg_reg[DLY-1] : beta_neg;

    cpt_park #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_park (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (fwd_tag),
        .x_mag   (x_mag),
        .x_neg   (x_neg),
        .y_mag   (y_mag),
        .y_neg   (y_neg),
        .c_mag   (c_mag_reg[DLY-1]),
        .c_neg   (c_neg_reg[DLY-1]),
        .s_mag   (s_mag_reg[DLY-1]),
        .s_neg   (s_neg_reg[DLY-1]),
        .tag_out (park_tag),
        .u       (u),
        .v       (v)
    );

    cpt_clarke_inv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_clarke_inv (
        .clk            (clk),
        .rst_n          (rst_n),
        .tag_in         (park_tag),
        .u              (u),
        .v              (v),
        .done           (done),
        .mode_out       (mode_out),
        .direct_out     (direct_out),
        .quadrature_out (quadrature_out),
        .phase_a_out    (phase_a_out),
        .phase_b_out    (phase_b_out),
        .phase_c_out    (phase_c_out)
    );

`ifndef SYNTHESIS
    a_done_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY) && (mode_out == $past(mode, LATENCY)))
        else $error("result strobe without matching request");

    a_fwd_phases_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mode_out == CPT_MODE_FWD)) |->
            (phase_a_out == '0) && (phase_b_out == '0) && (phase_c_out == '0))
        else $error("forward result with nonzero phase outputs");

    a_inv_dq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (mode_out == CPT_MODE_INV)) |->
            (direct_out == '0) && (quadrature_out == '0))
        else $error("inverse result with nonzero dq outputs");
`endif

endmodule

// ----- sim/clarke_park_transform_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for clarke_park_transform: directed corner requests, then
// random forward and inverse requests under varying start gaps. Depends on cpt_pkg.
module clarke_park_transform_tb;

    import cpt_pkg::*;

    localparam int DW          = CPT_DATA_WIDTH;
    localparam int ROUND_SHIFT = DW - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_REPORTS = 10;

    typedef logic signed [DW-1:0] sample_t;

    typedef struct packed {
        logic    mode;
        sample_t direct;
        sample_t quadrature;
        sample_t ph_a;
        sample_t ph_b;
        sample_t ph_c;
    } frame_result_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    logic    mode;
    sample_t phase_a;
    sample_t phase_b;
    sample_t phase_c;
    sample_t direct_in;
    sample_t quadrature_in;
    sample_t cos_angle;
    sample_t sin_angle;
    logic    done;
    sample_t direct_out;
    sample_t quadrature_out;
    sample_t phase_a_out;
    sample_t phase_b_out;
    sample_t phase_c_out;
    logic    mode_out;

    frame_result_t pending_results[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            idle_pct       = 0;

    clarke_park_transform dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .phase_a        (phase_a),
        .phase_b        (phase_b),
        .phase_c        (phase_c),
        .direct_in      (direct_in),
        .quadrature_in  (quadrature_in),
        .cos_angle      (cos_angle),
        .sin_angle      (sin_angle),
        .done           (done),
        .direct_out     (direct_out),
        .quadrature_out (quadrature_out),
        .phase_a_out    (phase_a_out),
        .phase_b_out    (phase_b_out),
        .phase_c_out    (phase_c_out),
        .mode_out       (mode_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction
    // round(v / 2^s), ties away from zero
    function automatic longint shift_round(input longint v, input int s);
        longint m;
        m = ((v < 0 ? -v : v) + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint scaled_product(input longint x, input longint y);
        return shift_round(x * y, ROUND_SHIFT);
    endfunction

    function automatic sample_t saturate(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return sample_t'(hi);
        if (v < lo)
            return sample_t'(lo);
        return sample_t'(v);
    endfunction

    function automatic frame_result_t compute_transform(
        input logic m, input sample_t a, input sample_t b, input sample_t c,
        input sample_t d, input sample_t q, input sample_t cs, input sample_t sn);
        frame_result_t r;
        longint        t;
        longint        tm;
        longint        alpha;
        longint        beta;
        longint        half;
        longint        bk;
        r      = '0;
        r.mode = m;
        if (m == CPT_MODE_FWD)
        begin
            t     = 2 * longint'(a) - longint'(b) - longint'(c);
            tm    = ((t < 0 ? -t : t) + 1) / 3;
            alpha = (t < 0) ? -tm : tm;
            beta  = shift_round((longint'(b) - longint'(c)) * longint'(CPT_K_INV_SQRT3),
                                CPT_K_SHIFT);
            r.direct     = saturate(scaled_product(alpha, cs) + scaled_product(beta, sn));
            r.quadrature = saturate(scaled_product(beta, cs) - scaled_product(alpha, sn));
        end
        else
        begin
            alpha  = scaled_product(d, cs) - scaled_product(q, sn);
            beta   = scaled_product(d, sn) + scaled_product(q, cs);
            half   = alpha * (longint'(1) << (CPT_K_SHIFT - 1));
            bk     = beta * longint'(CPT_K_SQRT3_HALF);
            r.ph_a = saturate(alpha);
            r.ph_b = saturate(shift_round(bk - half, CPT_K_SHIFT));
            r.ph_c = saturate(shift_round(-bk - half, CPT_K_SHIFT));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    always @(posedge clk)
    begin
        frame_result_t exp_r;
        frame_result_t act_r;
        if (rst_n && done)
        begin
            act_r = '{mode_out, direct_out, quadrature_out,
                      phase_a_out, phase_b_out, phase_c_out};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: mode %0d d %0d q %0d a %0d b %0d c %0d",
                             $realtime, act_r.mode, act_r.direct, act_r.quadrature,
                             act_r.ph_a, act_r.ph_b, act_r.ph_c);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (exp_r.mode !== act_r.mode || exp_r.direct !== act_r.direct ||
                    exp_r.quadrature !== act_r.quadrature || exp_r.ph_a !== act_r.ph_a ||
                    exp_r.ph_b !== act_r.ph_b || exp_r.ph_c !== act_r.ph_c)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("[%0t] mismatch: exp mode %0d d %0d q %0d a %0d b %0d c %0d",
                                 $realtime, exp_r.mode, exp_r.direct, exp_r.quadrature,
                                 exp_r.ph_a, exp_r.ph_b, exp_r.ph_c);
                        $display("              got mode %0d d %0d q %0d a %0d b %0d c %0d",
                                 act_r.mode, act_r.direct, act_r.quadrature,
                                 act_r.ph_a, act_r.ph_b, act_r.ph_c);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("clarke_park_transform test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    // each cycle idles with probability idle_pct; start stays high on return
    // so back-to-back requests need no extra edge
    task automatic send_request(
        input logic m, input sample_t a, input sample_t b, input sample_t c,
        input sample_t d, input sample_t q, input sample_t cs, input sample_t sn);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        mode          <= m;
        phase_a       <= a;
        phase_b       <= b;
        phase_c       <= c;
        direct_in     <= d;
        quadrature_in <= q;
        cos_angle     <= cs;
        sin_angle     <= sn;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(compute_transform(m, a, b, c, d, q, cs, sn));
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(DW-1){1'b0}}};
            1:       return {1'b0, {(DW-1){1'b1}}};
            2:       return sample_t'($urandom_range(0, 64)) - sample_t'(32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic test_forward_corners();
        sample_t mx;
        sample_t mn;
        sample_t z;
        mx = {1'b0, {(DW-1){1'b1}}};
        mn = {1'b1, {(DW-1){1'b0}}};
        z  = '0;
        send_request(CPT_MODE_FWD, z, z, z, z, z, z, z);
        send_request(CPT_MODE_FWD, mx, mn, mn, mx, mn, mx, z);
        send_request(CPT_MODE_FWD, mn, mx, mx, mn, mx, mn, mn);
        send_request(CPT_MODE_FWD, z, mx, mn, sample_t'(1234), sample_t'(-1234), z, mx);
        send_request(CPT_MODE_FWD, z, mn, mx, sample_t'(-5), sample_t'(7), mn, mx);
        send_request(CPT_MODE_FWD, sample_t'(16384), sample_t'(-8192), sample_t'(-8192),
                     mx, mx, mx, z);
        send_request(CPT_MODE_FWD, sample_t'(1), z, z, z, z, mx, z);  // rounds a third up
        send_request(CPT_MODE_FWD, z, z, sample_t'(1), z, z, mx, z);  // rounds a third down
        send_request(CPT_MODE_FWD, mx, mx, mx, mn, mn, mx, mx);
        send_request(CPT_MODE_FWD, mn, mn, mn, mx, mx, mn, mn);
        send_request(CPT_MODE_FWD, sample_t'(100), sample_t'(-300), sample_t'(200),
                     sample_t'(9), sample_t'(9), sample_t'(23170), sample_t'(23170));
    endtask

    task automatic test_inverse_corners();
        sample_t mx;
        sample_t mn;
        sample_t z;
        mx = {1'b0, {(DW-1){1'b1}}};
        mn = {1'b1, {(DW-1){1'b0}}};
        z  = '0;
        send_request(CPT_MODE_INV, mn, mx, sample_t'(3), z, z, z, z);
        send_request(CPT_MODE_INV, z, z, z, mx, mx, mx, mx);
        send_request(CPT_MODE_INV, mx, mx, mx, mn, mn, mn, mn);
        send_request(CPT_MODE_INV, z, z, z, mn, mx, mn, mx);
        send_request(CPT_MODE_INV, z, z, z, mx, z, mx, z);
        send_request(CPT_MODE_INV, z, z, z, z, mx, sample_t'(23170), sample_t'(23170));
        send_request(CPT_MODE_INV, z, z, z, sample_t'(1), sample_t'(1),
                     sample_t'(16384), sample_t'(16384));    // half-LSB ties
        send_request(CPT_MODE_INV, z, z, z, sample_t'(-1), sample_t'(-1),
                     sample_t'(16384), sample_t'(-16384));
        send_request(CPT_MODE_INV, mn, mn, mn, mx, mn, mn, mn);
        send_request(CPT_MODE_INV, sample_t'(77), sample_t'(-77), sample_t'(5),
                     sample_t'(12000), sample_t'(-20000), sample_t'(-23170),
                     sample_t'(23170));
    endtask

    task automatic test_random_requests(input int count, input int pct);
        int i;
        idle_pct = pct;
        for (i = 0; i < count; i++)
        begin
            send_request(logic'($urandom_range(0, 1)), pick_sample(), pick_sample(),
                         pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                         pick_sample());
            if (i == count / 2)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        mode          <= CPT_MODE_FWD;
        phase_a       <= '0;
        phase_b       <= '0;
        phase_c       <= '0;
        direct_in     <= '0;
        quadrature_in <= '0;
        cos_angle     <= '0;
        sin_angle     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_forward_corners();
        test_inverse_corners();
        wait_for_results();
        test_random_requests(300, 32);
        test_random_requests(300, 87);
        test_random_requests(300, 0);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("clarke_park_transform test passed");
        else
            $display("clarke_park_transform test failed");
        $finish;
    end

endmodule
